### rtl/core/aabb_ctq_pkg.sv
// shared constants and types for the box collision table
package aabb_ctq_pkg;

	localparam int DEF_MAX_BOXES  = 8192;
	localparam int DEF_COORD_BITS = 12;
	localparam int FIELD_BITS     = 12;
	localparam int INDEX_BITS     = 13;
	localparam int COUNT_BITS     = 14;
	localparam int WIDE_COORD     = 16;
	localparam int WIDE_IDX       = 17;
	localparam int DATA_BITS      = 32;
	localparam int ADDR_BITS      = 4;

	localparam logic [FIELD_BITS-1:0] PROBE_RESET = FIELD_BITS'(2);

	typedef enum logic [1:0] {
		REG_BOX_COUNT = 2'd0,
		REG_PROBE_W   = 2'd1,
		REG_PROBE_H   = 2'd2
	} reg_idx_t;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

endpackage

### rtl/core/aabb_ctq_if.sv
// valid/ready channel interfaces for items and results
interface aabb_ctq_in_if import aabb_ctq_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  cmd;
	logic [INDEX_BITS-1:0] box_index;
	logic [FIELD_BITS-1:0] box_x;
	logic [FIELD_BITS-1:0] box_y;
	logic [FIELD_BITS-1:0] box_w;
	logic [FIELD_BITS-1:0] box_h;
	logic [FIELD_BITS-1:0] point_x;
	logic [FIELD_BITS-1:0] point_y;

	modport source (output valid, cmd, box_index, box_x, box_y, box_w, box_h,
		point_x, point_y, input ready);
	modport sink (input valid, cmd, box_index, box_x, box_y, box_w, box_h,
		point_x, point_y, output ready);
endinterface

interface aabb_ctq_out_if ();
	logic valid;
	logic ready;
	logic hit;
	logic was_query;

	modport source (output valid, hit, was_query, input ready);
	modport sink (input valid, hit, was_query, output ready);
endinterface

### rtl/core/aabb_ctq_unit.sv
// shared overlap comparator: one stored box against the probe
module aabb_ctq_unit import aabb_ctq_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic [COORD_BITS-1:0] box_x,
	input  logic [COORD_BITS-1:0] box_y,
	input  logic [COORD_BITS-1:0] box_w,
	input  logic [COORD_BITS-1:0] box_h,
	input  logic [COORD_BITS-1:0] probe_x,
	input  logic [COORD_BITS-1:0] probe_y,
	input  logic [COORD_BITS:0]   probe_ex,
	input  logic [COORD_BITS:0]   probe_ey,
	input  logic                  probe_nz,
	output logic                  hit
);

	logic [COORD_BITS:0] box_ex;
	logic [COORD_BITS:0] box_ey;
	logic                x_ov;
	logic                y_ov;

	// positive sizes reduce the interval test to two strict compares per axis
	assign box_ex = {1'b0, box_x} + {1'b0, box_w};
	assign box_ey = {1'b0, box_y} + {1'b0, box_h};
	assign x_ov   = ({1'b0, box_x} < probe_ex) && ({1'b0, probe_x} < box_ex);
	assign y_ov   = ({1'b0, box_y} < probe_ey) && ({1'b0, probe_y} < box_ey);
	assign hit    = probe_nz && (box_w != '0) && (box_h != '0) && x_ov && y_ov;

endmodule

### rtl/core/aabb_collision_table_query_top.sv
// a query scans the entries below box_count capped at MAX_BOXES, then registers a hit flag
// a write stores its box in the table memory and is acknowledged with no hit
// the scan reads one table entry per cycle through the single read port of the memory
// the input stays blocked during a query's scan and while a result waits to be consumed
// one item at a time; the next item is taken once the result register is free
// arst_n clears control and configuration; table contents stay undefined until written
module aabb_collision_table_query_top import aabb_ctq_pkg::*; #(
	parameter int MAX_BOXES  = DEF_MAX_BOXES,
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready,
	aabb_ctq_in_if.sink          in_ch,
	aabb_ctq_out_if.source       out_ch
);

	localparam int IDX_W   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int CNT_W   = $clog2(MAX_BOXES + 1);
	localparam int ENTRY_W = 4 * COORD_BITS;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t                  state_q;
	logic [COUNT_BITS-1:0]   box_count_q;
	logic [FIELD_BITS-1:0]   probe_width_q;
	logic [FIELD_BITS-1:0]   probe_height_q;
	logic                    cfg_wr;
	reg_idx_t                cfg_idx;

	logic [ENTRY_W-1:0]      mem [MAX_BOXES];
	logic [ENTRY_W-1:0]      rd_s1;
	logic                    rd_valid_s1;

	logic [CNT_W-1:0]        scan_q;
	logic [CNT_W-1:0]        lim_q;
	logic                    acc_q;
	logic [COORD_BITS-1:0]   px_q;
	logic [COORD_BITS-1:0]   py_q;
	logic [COORD_BITS:0]     pex_q;
	logic [COORD_BITS:0]     pey_q;
	logic                    pnz_q;

	logic                    out_valid_q;
	logic                    out_hit_q;
	logic                    out_query_q;

	logic                    accept;
	logic                    wr_item;
	logic [WIDE_IDX-1:0]     idx_w;
	logic                    idx_ok;
	logic [WIDE_IDX-1:0]     bc_w;
	logic [WIDE_IDX-1:0]     bc_sat;
	logic [WIDE_COORD-1:0]   bx_w, by_w, bw_w, bh_w, px_w, py_w, pw_w, ph_w;
	logic [COORD_BITS-1:0]   pw_c;
	logic [COORD_BITS-1:0]   ph_c;
	logic [ENTRY_W-1:0]      wr_entry;
	logic                    unit_hit;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_comb begin
		case (cfg_idx)
			REG_BOX_COUNT: prdata = DATA_BITS'(box_count_q);
			REG_PROBE_W:   prdata = DATA_BITS'(probe_width_q);
			REG_PROBE_H:   prdata = DATA_BITS'(probe_height_q);
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_count_q    <= '0;
			probe_width_q  <= PROBE_RESET;
			probe_height_q <= PROBE_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_BOX_COUNT: box_count_q    <= pwdata[COUNT_BITS-1:0];
				REG_PROBE_W:   probe_width_q  <= pwdata[FIELD_BITS-1:0];
				REG_PROBE_H:   probe_height_q <= pwdata[FIELD_BITS-1:0];
				default: ;
			endcase
		end
	end

	// item decode
	assign in_ch.ready = (state_q == ST_IDLE) && (!out_valid_q || out_ch.ready);
	assign accept      = in_ch.valid && in_ch.ready;
	assign wr_item     = accept && (cmd_t'(in_ch.cmd) == CMD_WRITE);
	assign idx_w       = WIDE_IDX'(in_ch.box_index);
	assign idx_ok      = idx_w < WIDE_IDX'(MAX_BOXES);
	assign bc_w        = WIDE_IDX'(box_count_q);
	assign bc_sat      = (bc_w > WIDE_IDX'(MAX_BOXES)) ? WIDE_IDX'(MAX_BOXES) : bc_w;

	assign bx_w = WIDE_COORD'(in_ch.box_x);
	assign by_w = WIDE_COORD'(in_ch.box_y);
	assign bw_w = WIDE_COORD'(in_ch.box_w);
	assign bh_w = WIDE_COORD'(in_ch.box_h);
	assign px_w = WIDE_COORD'(in_ch.point_x);
	assign py_w = WIDE_COORD'(in_ch.point_y);
	assign pw_w = WIDE_COORD'(probe_width_q);
	assign ph_w = WIDE_COORD'(probe_height_q);
	assign pw_c = pw_w[COORD_BITS-1:0];
	assign ph_c = ph_w[COORD_BITS-1:0];

	assign wr_entry = {bh_w[COORD_BITS-1:0], bw_w[COORD_BITS-1:0],
		by_w[COORD_BITS-1:0], bx_w[COORD_BITS-1:0]};

	// box table
	always_ff @(posedge clk) begin
		if (wr_item && idx_ok) begin
			mem[idx_w[IDX_W-1:0]] <= wr_entry;
		end
		if (state_q == ST_SCAN) begin
			rd_s1 <= mem[scan_q[IDX_W-1:0]];
		end
	end

	aabb_ctq_unit #(
		.COORD_BITS (COORD_BITS)
	) u_unit (
		.box_x    (rd_s1[COORD_BITS-1:0]),
		.box_y    (rd_s1[2*COORD_BITS-1:COORD_BITS]),
		.box_w    (rd_s1[3*COORD_BITS-1:2*COORD_BITS]),
		.box_h    (rd_s1[4*COORD_BITS-1:3*COORD_BITS]),
		.probe_x  (px_q),
		.probe_y  (py_q),
		.probe_ex (pex_q),
		.probe_ey (pey_q),
		.probe_nz (pnz_q),
		.hit      (unit_hit)
	);

	// probe capture
	always_ff @(posedge clk) begin
		if (accept) begin
			px_q  <= px_w[COORD_BITS-1:0];
			py_q  <= py_w[COORD_BITS-1:0];
			pex_q <= {1'b0, px_w[COORD_BITS-1:0]} + {1'b0, pw_c};
			pey_q <= {1'b0, py_w[COORD_BITS-1:0]} + {1'b0, ph_c};
			pnz_q <= (pw_c != '0) && (ph_c != '0);
		end
	end

	// scan sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_q      <= '0;
			lim_q       <= '0;
			acc_q       <= 1'b0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			out_hit_q   <= 1'b0;
			out_query_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					rd_valid_s1 <= 1'b0;
					if (accept) begin
						if (wr_item) begin
							out_valid_q <= 1'b1;
							out_hit_q   <= 1'b0;
							out_query_q <= 1'b0;
						end else begin
							scan_q  <= '0;
							lim_q   <= bc_sat[CNT_W-1:0];
							acc_q   <= 1'b0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					acc_q       <= acc_q | (rd_valid_s1 & unit_hit);
					rd_valid_s1 <= (scan_q != lim_q);
					if (scan_q != lim_q) begin
						scan_q <= scan_q + CNT_W'(1);
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					out_valid_q <= 1'b1;
					out_hit_q   <= acc_q | (rd_valid_s1 & unit_hit);
					out_query_q <= 1'b1;
					rd_valid_s1 <= 1'b0;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.hit       = out_hit_q;
	assign out_ch.was_query = out_query_q;

endmodule

### rtl/core/aabb_ctq_checker.sv
// port-level checks for the box collision table, bound to the top level
module aabb_ctq_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_cmd,
	input logic out_valid,
	input logic out_ready,
	input logic out_hit,
	input logic out_query
);

	// a write transaction is acknowledged in the next cycle with no hit
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_cmd |=> out_valid && !out_query && !out_hit)
		else $error("write not acknowledged in the next cycle");

	// a query transaction blocks new items while the table is scanned
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_cmd |=> !in_ready)
		else $error("item taken during a scan");

	// no new item while an unconsumed result is held
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid || out_ready)
		else $error("ready while the result register is full");

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_hit) && $stable(out_query))
		else $error("stalled result changed");

endmodule

bind aabb_collision_table_query_top aabb_ctq_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_cmd    (in_ch.cmd),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_hit   (out_ch.hit),
	.out_query (out_ch.was_query)
);
